// ----- hdl/lii_pkg.sv -----
// Shared types and constants for the line crossing pipeline.
`default_nettype none
package lii_pkg;

  localparam int unsigned DivSteps = 32;
  localparam int unsigned ThrWidth = 28;

  typedef struct packed {
    logic signed [31:0] o1x;
    logic signed [31:0] o1y;
    logic signed [15:0] d1x;
    logic signed [15:0] d1y;
    logic signed [31:0] o2x;
    logic signed [31:0] o2y;
    logic signed [15:0] d2x;
    logic signed [15:0] d2y;
  } geo_t;

  // Word held by one divider cell: two quotient lanes sharing one divisor.
  typedef struct packed {
    geo_t        geo;
    logic        par;
    logic        neg1;
    logic        neg2;
    logic        ovf1;
    logic        ovf2;
    logic [31:0] ds;
    logic [31:0] rem1;
    logic [31:0] rem2;
    logic [31:0] low1;
    logic [31:0] low2;
    logic [31:0] q1;
    logic [31:0] q2;
  } div_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } res_t;

endpackage
`default_nettype wire

// ----- hdl/lii_front.sv -----
// Front stages: origin differences, cross products, magnitudes and divider setup.
`default_nettype none
module lii_front
  import lii_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire geo_t                geo_i,
  input  wire logic [ThrWidth-1:0] thr_i,
  output logic                     valid_o,
  output div_t                     div_o
);

  logic               va_q;
  geo_t               geo_a_q;
  logic signed [32:0] px_q, py_q, s_a_q;

  logic               vb_q;
  geo_t               geo_b_q;
  logic signed [49:0] n1_q, n2_q;
  logic               par_q, sneg_q;
  logic [31:0]        as_q;

  logic signed [32:0] px_d, py_d, s_d;
  logic signed [49:0] n1_d, n2_d;
  logic [31:0]        as_d;
  logic [48:0]        an1, an2;
  div_t               div_d;

  always_comb begin
    px_d = geo_i.o2x - geo_i.o1x;
    py_d = geo_i.o2y - geo_i.o1y;
    s_d  = geo_i.d1x * geo_i.d2y - geo_i.d1y * geo_i.d2x;
  end

  always_comb begin
    n1_d = px_q * geo_a_q.d2y - py_q * geo_a_q.d2x;
    n2_d = px_q * geo_a_q.d1y - py_q * geo_a_q.d1x;
    as_d = s_a_q[32] ? 32'(-s_a_q) : 32'(s_a_q);
  end

  always_comb begin
    an1 = n1_q[49] ? 49'(-n1_q) : 49'(n1_q);
    an2 = n2_q[49] ? 49'(-n2_q) : 49'(n2_q);
    div_d.geo  = geo_b_q;
    div_d.par  = par_q;
    div_d.neg1 = n1_q[49] ^ sneg_q;
    div_d.neg2 = n2_q[49] ^ sneg_q;
    // The quotient reaches 2^32 when |n| * 2^14 >= |s| * 2^32.
    div_d.ovf1 = {1'b0, an1} >= (50'(as_q) << 18);
    div_d.ovf2 = {1'b0, an2} >= (50'(as_q) << 18);
    div_d.ds   = as_q;
    div_d.rem1 = {1'b0, an1[48:18]};
    div_d.rem2 = {1'b0, an2[48:18]};
    div_d.low1 = {an1[17:0], 14'b0};
    div_d.low2 = {an2[17:0], 14'b0};
    div_d.q1   = '0;
    div_d.q2   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      va_q    <= valid_i;
      vb_q    <= va_q;
      valid_o <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo_a_q <= geo_i;
      px_q    <= px_d;
      py_q    <= py_d;
      s_a_q   <= s_d;
      geo_b_q <= geo_a_q;
      n1_q    <= n1_d;
      n2_q    <= n2_d;
      as_q    <= as_d;
      par_q   <= as_d <= {4'b0, thr_i};
      sneg_q  <= s_a_q[32];
      div_o   <= div_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lii_div_cell.sv -----
// One restoring division step for both quotient lanes.
`default_nettype none
module lii_div_cell
  import lii_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  wire div_t div_i,
  output logic      valid_o,
  output div_t      div_o
);

  div_t div_d;
  logic [32:0] r1, r2;
  logic        ge1, ge2;

  always_comb begin
    div_d = div_i;
    r1  = {div_i.rem1, div_i.low1[31]};
    r2  = {div_i.rem2, div_i.low2[31]};
    ge1 = r1 >= {1'b0, div_i.ds};
    ge2 = r2 >= {1'b0, div_i.ds};
    div_d.rem1 = ge1 ? 32'(r1 - {1'b0, div_i.ds}) : r1[31:0];
    div_d.rem2 = ge2 ? 32'(r2 - {1'b0, div_i.ds}) : r2[31:0];
    div_d.low1 = div_i.low1 << 1;
    div_d.low2 = div_i.low2 << 1;
    div_d.q1   = {div_i.q1[30:0], ge1};
    div_d.q2   = {div_i.q2[30:0], ge2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_o <= div_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lii_back.sv -----
// Back stages: quotient signs and range, line points, rounded mean.
`default_nettype none
module lii_back
  import lii_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  wire div_t div_i,
  output logic      valid_o,
  output res_t      res_o
);

  logic               ve_q, vf_q;
  geo_t               geo_e_q;
  logic signed [31:0] t1_q, t2_q, t1f_q, t2f_q;
  logic               fe_q, ff_q;
  logic signed [47:0] p1x_q, p2x_q, p1y_q, p2y_q;
  logic signed [32:0] osx_q, osy_q;

  logic               bad1, bad2, found_d;
  logic signed [31:0] t1_d, t2_d;
  logic signed [50:0] sx, sy, rx, ry;
  res_t               res_d;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -51'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  always_comb begin
    // A negative quotient may reach 2^31 in magnitude, a positive one may not.
    bad1 = div_i.neg1 ? (div_i.q1 > 32'h80000000) : div_i.q1[31];
    bad2 = div_i.neg2 ? (div_i.q2 > 32'h80000000) : div_i.q2[31];
    found_d = !div_i.par && !div_i.ovf1 && !div_i.ovf2 && !bad1 && !bad2;
    t1_d = div_i.neg1 ? -div_i.q1 : div_i.q1;
    t2_d = div_i.neg2 ? -div_i.q2 : div_i.q2;
    if (!found_d) begin
      t1_d = '0;
      t2_d = '0;
    end
  end

  always_comb begin
    sx = (51'(osx_q) <<< 14) + p1x_q + p2x_q;
    sy = (51'(osy_q) <<< 14) + p1y_q + p2y_q;
    rx = (sx + 51'sd16384) >>> 15;
    ry = (sy + 51'sd16384) >>> 15;
    res_d.found = ff_q;
    res_d.t1    = t1f_q;
    res_d.t2    = t2f_q;
    res_d.cx    = ff_q ? sat32(rx) : '0;
    res_d.cy    = ff_q ? sat32(ry) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q    <= 1'b0;
      vf_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      ve_q    <= valid_i;
      vf_q    <= ve_q;
      valid_o <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo_e_q <= div_i.geo;
      t1_q    <= t1_d;
      t2_q    <= t2_d;
      fe_q    <= found_d;
      p1x_q   <= t1_q * geo_e_q.d1x;
      p2x_q   <= t2_q * geo_e_q.d2x;
      p1y_q   <= t1_q * geo_e_q.d1y;
      p2y_q   <= t2_q * geo_e_q.d2y;
      osx_q   <= geo_e_q.o1x + geo_e_q.o2x;
      osy_q   <= geo_e_q.o1y + geo_e_q.o2y;
      t1f_q   <= t1_q;
      t2f_q   <= t2_q;
      ff_q    <= fe_q;
      res_o   <= res_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/line_line_intersection.sv -----
// Top level of the two-line crossing pipeline.
//
// Input stream (s_axis_*): one word carries two lines, each an origin in
// signed Q16.16 and a direction in signed Q2.14. Output stream (m_axis_*):
// one word per input word, with both line parameters and the crossing point
// in tdata and the found flag in tuser. cfg_we_i/cfg_wdata_i load the
// parallel threshold; write it only while no word is in flight.
//
// An accepted word reaches tvalid through three setup stages, a chain of
// 32 division cells that each settle one quotient bit of both parameters,
// three stages for range check, products and rounding, and the output
// register. Throughput is one word per cycle while the receiver does not
// stall; the chain is fully pipelined.
//
// Reset empties the pipeline and loads the threshold with 1. When the
// receiver stalls, one more word moves into a skid register and the whole
// pipeline then holds; tready drops only while that skid register is full.
`default_nettype none
module line_line_intersection
  import lii_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // o1x, o1y, d1x, d1y, o2x, o2y, d2x, d2y
  input  wire logic [191:0]        s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // first_param, second_param, cross_x, cross_y
  output logic [127:0]             m_axis_tdata,
  // found
  output logic [0:0]               m_axis_tuser,
  input  wire logic                cfg_we_i,
  input  wire logic [ThrWidth-1:0] cfg_wdata_i
);

  logic [ThrWidth-1:0] thr_q;
  logic                en, skid_v_q, out_v_q, rv;
  res_t                res, skid_q, out_q;
  geo_t                geo;
  logic                dv [DivSteps+1];
  div_t                dd [DivSteps+1];

  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  always_comb begin
    geo.o1x = s_axis_tdata[31:0];
    geo.o1y = s_axis_tdata[63:32];
    geo.d1x = s_axis_tdata[79:64];
    geo.d1y = s_axis_tdata[95:80];
    geo.o2x = s_axis_tdata[127:96];
    geo.o2y = s_axis_tdata[159:128];
    geo.d2x = s_axis_tdata[175:160];
    geo.d2y = s_axis_tdata[191:176];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrWidth'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  lii_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .geo_i   (geo),
    .thr_i   (thr_q),
    .valid_o (dv[0]),
    .div_o   (dd[0])
  );

  for (genvar i = 0; i < DivSteps; i++) begin : g_cell
    lii_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[i]),
      .div_i   (dd[i]),
      .valid_o (dv[i+1]),
      .div_o   (dd[i+1])
    );
  end

  lii_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv[DivSteps]),
    .div_i   (dd[DivSteps]),
    .valid_o (rv),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q <= rv;
    end else if (rv) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (!out_v_q || m_axis_tready) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.cy, out_q.cx, out_q.t2, out_q.t1};
  assign m_axis_tuser  = out_q.found;

endmodule
`default_nettype wire

// ----- hdl/lii_checker.sv -----
// Port-level checks for the line crossing block, bound to its top level.
`default_nettype none
module lii_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [127:0] m_axis_tdata,
  input wire logic [0:0]   m_axis_tuser
);

  // A stalled output word keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // A word without a crossing carries only zeros.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 128'd0)
    else $error("nonzero payload on a word without a crossing");

  // Input is held off only while an output word is waiting.
  a_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input held off with no output pending");

  // The skid register drains before input resumes.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && !m_axis_tready |=> !s_axis_tready)
    else $error("input resumed while output still stalled");

endmodule

bind line_line_intersection lii_checker u_lii_checker (.*);
`default_nettype wire

// ----- dv/tb_line_line_intersection.sv -----
// Self-checking testbench for the two-line crossing pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tb_line_line_intersection;
  import lii_pkg::*;

  localparam int unsigned PipeDepth = 39;
  localparam longint unsigned CycleLimit = 2000000;

  typedef struct {
    geo_t g;
    bit   typed;
    res_t want;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [191:0]        s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [127:0]        m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                cfg_we_i = 1'b0;
  logic [ThrWidth-1:0] cfg_wdata_i = '0;

  logic [ThrWidth-1:0] thr_shadow = 28'd1;
  res_t                pending_results[$];
  int unsigned         errors = 0;
  int unsigned         words_out = 0;
  int unsigned         hold_left = 0;
  bit                  long_hold_done = 1'b0;
  bit                  no_idle = 1'b0;
  longint unsigned     cycles = 0;

  always #1 clk_i = ~clk_i;

  line_line_intersection u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  function automatic geo_t mk_geo(longint a, longint b, longint c, longint d,
                                  longint e, longint f, longint g2, longint h);
    geo_t g;
    g.o1x = a[31:0]; g.o1y = b[31:0]; g.d1x = c[15:0]; g.d1y = d[15:0];
    g.o2x = e[31:0]; g.o2y = f[31:0]; g.d2x = g2[15:0]; g.d2y = h[15:0];
    return g;
  endfunction

  // Rounds a Q.30 sum of two points to the Q16.16 mean, saturating.
  function automatic logic [31:0] mean_point(longint v);
    longint m;
    m = (v + 64'sd16384) >>> 15;
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    if (m < -64'sd2147483648) m = -64'sd2147483648;
    return m[31:0];
  endfunction

  function automatic res_t crossing(geo_t g, logic [ThrWidth-1:0] thr);
    longint px, py, s, mag, n1, n2, t1, t2, sx, sy;
    res_t r;
    r = '0;
    px = longint'(g.o2x) - longint'(g.o1x);
    py = longint'(g.o2y) - longint'(g.o1y);
    s = longint'(g.d1x) * longint'(g.d2y) - longint'(g.d1y) * longint'(g.d2x);
    mag = (s < 0) ? -s : s;
    if (mag <= longint'({36'd0, thr})) return r;
    n1 = px * longint'(g.d2y) - py * longint'(g.d2x);
    n2 = px * longint'(g.d1y) - py * longint'(g.d1x);
    t1 = (n1 * 16384) / s;
    t2 = (n2 * 16384) / s;
    if (t1 > 64'sd2147483647 || t1 < -64'sd2147483648 ||
        t2 > 64'sd2147483647 || t2 < -64'sd2147483648) return r;
    sx = longint'(g.o1x) * 16384 + t1 * longint'(g.d1x)
       + longint'(g.o2x) * 16384 + t2 * longint'(g.d2x);
    sy = longint'(g.o1y) * 16384 + t1 * longint'(g.d1y)
       + longint'(g.o2y) * 16384 + t2 * longint'(g.d2y);
    r.found = 1'b1;
    r.t1 = t1[31:0];
    r.t2 = t2[31:0];
    r.cx = mean_point(sx);
    r.cy = mean_point(sy);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 45);
  endfunction

  task automatic send_word(input geo_t g, input bit typed, input res_t want);
    int unsigned gap;
    s_axis_tdata <= {g.d2y, g.d2x, g.o2y, g.o2x, g.d1y, g.d1x, g.o1y, g.o1x};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.insert(pending_results.size(),
                           typed ? want : crossing(g, thr_shadow));
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_write(input logic [ThrWidth-1:0] thr);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 10) @(posedge clk_i);
    cfg_wdata_i <= thr;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thr_shadow = thr;
  endtask

  function automatic longint rand_dir();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return (r == 0) ? -32768 : 32767;
    if (r < 6) return longint'($urandom_range(0, 65535)) - 32768;
    return longint'($urandom_range(0, 8192)) - 4096;
  endfunction

  function automatic geo_t rand_geo();
    geo_t g;
    int unsigned kind;
    longint c, d;
    kind = $urandom_range(0, 9);
    g = mk_geo($urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom(), $urandom());
    if (kind < 5) begin
      // Moderate origins keep most parameters inside the Q16.16 range.
      g.o1x = $signed(32'($urandom_range(0, 32'h00FFFFFF))) - 32'sh0080_0000;
      g.o1y = $signed(32'($urandom_range(0, 32'h00FFFFFF))) - 32'sh0080_0000;
      g.o2x = $signed(32'($urandom_range(0, 32'h00FFFFFF))) - 32'sh0080_0000;
      g.o2y = $signed(32'($urandom_range(0, 32'h00FFFFFF))) - 32'sh0080_0000;
      c = rand_dir(); d = rand_dir();
      g.d1x = c[15:0]; g.d1y = d[15:0];
      c = rand_dir(); d = rand_dir();
      g.d2x = c[15:0]; g.d2y = d[15:0];
    end else if (kind < 7) begin
      // Nearly parallel: second direction is the first plus a small wobble.
      c = longint'(g.d1x) + longint'($urandom_range(0, 6)) - 3;
      d = longint'(g.d1y) + longint'($urandom_range(0, 6)) - 3;
      g.d2x = c[15:0]; g.d2y = d[15:0];
    end
    return g;
  endfunction

  // Result check and receiver back-pressure.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, got found=%0d data=%h", $time,
                 m_axis_tuser, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser[0] !== want.found) begin
          errors++;
          $display("%0t: found exp %0d got %0d", $time, want.found, m_axis_tuser[0]);
        end
        if (m_axis_tdata[31:0] !== want.t1) begin
          errors++;
          $display("%0t: first_param exp %h got %h", $time, want.t1, m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[63:32] !== want.t2) begin
          errors++;
          $display("%0t: second_param exp %h got %h", $time, want.t2, m_axis_tdata[63:32]);
        end
        if (m_axis_tdata[95:64] !== want.cx) begin
          errors++;
          $display("%0t: cross_x exp %h got %h", $time, want.cx, m_axis_tdata[95:64]);
        end
        if (m_axis_tdata[127:96] !== want.cy) begin
          errors++;
          $display("%0t: cross_y exp %h got %h", $time, want.cy, m_axis_tdata[127:96]);
        end
      end
    end
    if (!long_hold_done && words_out >= 300) begin
      long_hold_done <= 1'b1;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= (hold_left == 1);
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0:       hold_left <= $urandom_range(8, 40);
        1, 2, 3: m_axis_tready <= 1'b0;
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    logic [ThrWidth-1:0] thr_plan[4];
    res_t none;
    res_t hit;
    none = '0;
    hit = '0;
    hit.found = 1'b1;

    // Reset state: threshold 1.
    rows.insert(rows.size(), '{mk_geo(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
    rows.insert(rows.size(), '{mk_geo(0, 0, 16384, 0, 0, 0, 0, 16384), 1'b1, hit});
    hit.t1 = 32'sd65536; hit.t2 = -32'sd65536; hit.cx = 32'sd65536;
    rows.insert(rows.size(), '{mk_geo(0, 0, 16384, 0, 65536, 65536, 0, 16384),
                               1'b1, hit});
    // Identical directions are parallel whatever the origins.
    rows.insert(rows.size(), '{mk_geo(5, 7, 9000, -300, 100, 200, 9000, -300),
                               1'b1, none});
    // Smallest cross product above the threshold, with a huge offset: overflow.
    rows.insert(rows.size(), '{mk_geo(-2147483648, -2147483648, 1, 0,
                                      2147483647, 2147483647, 0, 2), 1'b1, none});
    // Cross product exactly at the threshold counts as parallel.
    rows.insert(rows.size(), '{mk_geo(3, 4, 1, 0, 9, 9, 0, 1), 1'b1, none});
    // Extremes of origins and directions, checked by the predictor.
    rows.insert(rows.size(), '{mk_geo(-2147483648, 2147483647, -32768, 32767,
                                      2147483647, -2147483648, 32767, -32768),
                               1'b0, none});
    rows.insert(rows.size(), '{mk_geo(2147483647, 2147483647, -32768, -32768,
                                      -2147483648, -2147483648, 32767, 0),
                               1'b0, none});
    rows.insert(rows.size(), '{mk_geo(2147483647, 2147483647, 32767, 0,
                                      2147483647, 2147483647, 0, 32767),
                               1'b0, none});
    rows.insert(rows.size(), '{mk_geo(2147483000, 2147483000, 16384, 16384,
                                      2147483000, -2147483000, 16384, -16384),
                               1'b0, none});
    rows.insert(rows.size(), '{mk_geo(-2147483648, -2147483648, -32768, 0,
                                      -2147483648, -2147483648, 0, -32768),
                               1'b0, none});
    // Odd parameters give half-way means that exercise the rounding tie.
    rows.insert(rows.size(), '{mk_geo(1, 1, 16384, 0, 2, 3, 0, 16384), 1'b0, none});
    rows.insert(rows.size(), '{mk_geo(-1, -1, 3, 5, 7, -11, -5, 3), 1'b0, none});
    rows.insert(rows.size(), '{mk_geo(100000, -77777, 12345, -6789, -33333, 4444,
                                      -1111, 22222), 1'b0, none});
    rows.insert(rows.size(), '{mk_geo(0, 0, 1, 1, 65536, 0, 1, -1), 1'b0, none});

    thr_plan[0] = 28'd0;
    thr_plan[1] = 28'hFFFFFFF;
    thr_plan[2] = 28'($urandom_range(2, 32'h00FF_FFFF));
    thr_plan[3] = 28'd1;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_word(rows[i].g, rows[i].typed, rows[i].want);
    for (int w = 0; w < 360; w++) begin
      if (w % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_word(rand_geo(), 1'b0, none);
    end
    foreach (thr_plan[p]) begin
      drain_and_write(thr_plan[p]);
      for (int w = 0; w < 270; w++) begin
        if (w % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_word(rand_geo(), 1'b0, none);
      end
    end
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 10) @(posedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
